FILE: rtl/core/bmpc_pkg.sv
// Shared types and constants of the barometric compensation core.
`default_nettype none
package bmpc_pkg;

  localparam int unsigned DIV_STAGES = 32;
  // Cycles from an accepted start to its result strobe.
  localparam int unsigned PIPE_LAT   = 16 + 2 * DIV_STAGES;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] P_COEF_A   = 32'd3038;
  localparam logic [31:0] P_COEF_B   = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_OFFSET   = 32'd3791;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] B7_TOP     = 32'h8000_0000;
  localparam logic [31:0] X3_BIAS    = 32'd32768;

  typedef enum logic [1:0] {
    CFG_CAL_A = 2'd0,
    CFG_CAL_B = 2'd1,
    CFG_CAL_C = 2'd2,
    CFG_OSS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pascal;
    logic               divide_fault;
  } out_t;

  // Data that rides along with a divide.
  typedef struct packed {
    logic [31:0] word;
    logic [23:0] up;
    logic        neg;
    logic        fault;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/core/bmpc_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
`default_nettype none
module bmpc_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [31:0]         num_i,
  input  wire logic [31:0]         den_i,
  input  wire bmpc_pkg::side_t     side_i,
  output logic                     valid_o,
  output logic [31:0]              quo_o,
  output bmpc_pkg::side_t          side_o
);
  import bmpc_pkg::*;

  logic [31:0] rem_q [DIV_STAGES];
  logic [31:0] nq_q  [DIV_STAGES];   // numerator shifts out, quotient shifts in
  logic [31:0] den_q [DIV_STAGES];
  side_t       side_q[DIV_STAGES];
  logic        vld_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0] rem_in, nq_in, den_in;
    side_t       side_in;
    logic        vld_in;
    logic [32:0] trial, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[31]};
      diff  = trial - {1'b0, den_in};
      ge    = ~diff[32];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[31:0] : trial[31:0];
      nq_q[k]   <= {nq_in[30:0], ge};
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quo_o   = nq_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/core/barometric_temp_pressure_compensation_core.sv
// Top level: pipelined temperature and pressure compensation.
//
//   channel  | ports                                  | transfer
//   ---------+----------------------------------------+----------------------------
//   command  | start_i, busy_o, cmd_i                 | start_i high, busy_o low
//   result   | result_valid_o, result_o               | one-cycle strobe, no stall
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i        | write when cfg_we_i high
//
// One transaction per cycle; busy_o stays low. Each result passes through the
// arithmetic stages, two 32-stage dividers and in/out regs; both dividers
// resolve one quotient bit per stage. Reset clears only the valid bits
// and the configuration. The receiver cannot stall, so nothing is held back.
`default_nettype none
module barometric_temp_pressure_compensation_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire bmpc_pkg::in_t cmd_i,
  output logic               result_valid_o,
  output bmpc_pkg::out_t     result_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_data_i
);
  import bmpc_pkg::*;

  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAL_A: cal_a_q <= cfg_data_i;
        CFG_CAL_B: cal_b_q <= cfg_data_i;
        CFG_CAL_C: cal_c_q <= cfg_data_i[31:0];
        CFG_OSS:   oss_q   <= cfg_data_i[1:0];
        default:   ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_a_q[63]}}, cal_a_q[63:48]};
  assign ac2 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
  assign ac3 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
  assign ac4 = {16'd0, cal_a_q[15:0]};
  assign ac5 = {16'd0, cal_b_q[63:48]};
  assign ac6 = {16'd0, cal_b_q[47:32]};
  assign b1  = {{16{cal_b_q[31]}}, cal_b_q[31:16]};
  assign b2  = {{16{cal_b_q[15]}}, cal_b_q[15:0]};
  assign mc  = {{16{cal_c_q[31]}}, cal_c_q[31:16]};
  assign md  = {{16{cal_c_q[15]}}, cal_c_q[15:0]};

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits of the arithmetic stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic v12_q, v13_q, v14_q, v15_q, v16_q;
  logic d1_vld, d2_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <= '0;
      {v9_q, v10_q, v11_q, v12_q, v13_q, v14_q, v15_q, v16_q} <= '0;
    end else begin
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= d1_vld;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= d2_vld;
      v14_q <= v13_q;
      v15_q <= v14_q;
      v16_q <= v15_q;
    end
  end

  // ---- temperature front end ----
  logic [31:0] a1_q, m2_q;
  logic [23:0] up1_q, up2_q;
  logic [31:0] up_full;
  assign up_full = {8'd0, cmd_i.raw_pressure_bytes} >> (4'd8 - {2'b00, oss_q});

  logic [31:0] x1t, tdiv;
  assign x1t  = $signed(m2_q) >>> 15;
  assign tdiv = x1t + md;

  logic [31:0] s3_mag_n, s3_mag_d;
  logic [31:0] mc_sh;
  assign mc_sh    = mc << 11;
  assign s3_mag_n = mc_sh[31] ? (32'd0 - mc_sh) : mc_sh;
  assign s3_mag_d = tdiv[31] ? (32'd0 - tdiv) : tdiv;

  logic [31:0] n3_q, dn3_q;
  side_t       side3_q, side_d1;
  logic [31:0] quo1;

  always_ff @(posedge clk_i) begin
    a1_q  <= {16'd0, cmd_i.raw_temperature} - ac6;
    up1_q <= up_full[23:0];
    m2_q  <= a1_q * ac5;
    up2_q <= up1_q;
    n3_q  <= s3_mag_n;
    dn3_q <= s3_mag_d;
    side3_q.word  <= x1t;
    side3_q.up    <= up2_q;
    side3_q.neg   <= mc_sh[31] ^ tdiv[31];
    side3_q.fault <= (tdiv == 32'd0);
  end

  bmpc_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (n3_q),
    .den_i   (dn3_q),
    .side_i  (side3_q),
    .valid_o (d1_vld),
    .quo_o   (quo1),
    .side_o  (side_d1)
  );

  // ---- pressure path ----
  logic [31:0] b5_q, b6_q, t5_q, sq6_q, p2_q, p3_q;
  logic [31:0] s7_q, x2a_q, x1b_q, m1_q, m2b_q, x2a8_q, x1b8_q;
  logic [31:0] b3_q, x3c_q, b4m_q, dif_q, b4_q, b7_q;
  logic [23:0] up4_q, up5_q, up6_q, up7_q, up8_q, up9_q;
  logic [31:0] t6_q, t7_q, t8_q, t9_q, t10_q, t11_q;
  logic        f4_q, f5_q, f6_q, f7_q, f8_q, f9_q, f10_q, f11_q;

  // signed shifts are wrapped in $unsigned so an unsigned neighbor
  // does not turn them into logical shifts
  logic [31:0] x3p, b3_n, x3b_n, b4_n;
  assign x3p   = $unsigned($signed(m1_q) >>> 11) + x2a8_q;
  assign b3_n  = $signed(((ac1 << 2) + x3p) << oss_q) + 32'sd2 >>> 2;
  assign x3b_n = $signed(x1b8_q + $unsigned($signed(m2b_q) >>> 16) + 32'd2) >>> 2;
  assign b4_n  = b4m_q >> 15;

  always_ff @(posedge clk_i) begin
    b5_q  <= side_d1.word + (side_d1.neg ? (32'd0 - quo1) : quo1);
    up4_q <= side_d1.up;
    f4_q  <= side_d1.fault;

    b6_q  <= b5_q - B6_OFFSET;
    t5_q  <= $signed(b5_q + 32'd8) >>> 4;
    up5_q <= up4_q;
    f5_q  <= f4_q;

    sq6_q <= b6_q * b6_q;
    p2_q  <= ac2 * b6_q;
    p3_q  <= ac3 * b6_q;
    t6_q  <= t5_q;
    up6_q <= up5_q;
    f6_q  <= f5_q;

    s7_q  <= $signed(sq6_q) >>> 12;
    x2a_q <= $signed(p2_q) >>> 11;
    x1b_q <= $signed(p3_q) >>> 13;
    t7_q  <= t6_q;
    up7_q <= up6_q;
    f7_q  <= f6_q;

    m1_q   <= b2 * s7_q;
    m2b_q  <= b1 * s7_q;
    x2a8_q <= x2a_q;
    x1b8_q <= x1b_q;
    t8_q   <= t7_q;
    up8_q  <= up7_q;
    f8_q   <= f7_q;

    b3_q  <= b3_n;
    x3c_q <= x3b_n + X3_BIAS;
    t9_q  <= t8_q;
    up9_q <= up8_q;
    f9_q  <= f8_q;

    b4m_q <= ac4 * x3c_q;
    dif_q <= {8'd0, up9_q} - b3_q;
    t10_q <= t9_q;
    f10_q <= f9_q;

    b4_q  <= b4_n;
    b7_q  <= dif_q * (B7_SCALE >> oss_q);
    t11_q <= t10_q;
    f11_q <= f10_q | (b4_n == 32'd0);
  end

  // B7 overflow branch: shift before or after the divide
  logic [31:0] n12_q, dn12_q, quo2;
  side_t       side12_q, side_d2;

  always_ff @(posedge clk_i) begin
    n12_q          <= (b7_q < B7_TOP) ? (b7_q << 1) : b7_q;
    dn12_q         <= b4_q;
    side12_q.word  <= t11_q;
    side12_q.up    <= '0;
    side12_q.neg   <= !(b7_q < B7_TOP);
    side12_q.fault <= f11_q;
  end

  bmpc_div u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v12_q),
    .num_i   (n12_q),
    .den_i   (dn12_q),
    .side_i  (side12_q),
    .valid_o (d2_vld),
    .quo_o   (quo2),
    .side_o  (side_d2)
  );

  logic [31:0] p13_q, p14_q, p15_q, sqp_q, x2p_q, x1m_q, x2s_q;
  logic [31:0] t13_q, t14_q, t15_q, pa13;
  logic        f13_q, f14_q, f15_q;
  logic [31:0] p_fin;
  out_t        res_q;

  assign pa13  = $signed(p13_q) >>> 8;
  assign p_fin = p15_q +
                 $unsigned($signed($unsigned($signed(x1m_q) >>> 16) + x2s_q + P_OFFSET)
                           >>> 4);

  always_ff @(posedge clk_i) begin
    p13_q <= side_d2.neg ? (quo2 << 1) : quo2;
    t13_q <= side_d2.word;
    f13_q <= side_d2.fault;

    sqp_q <= pa13 * pa13;
    x2p_q <= P_COEF_B * p13_q;
    p14_q <= p13_q;
    t14_q <= t13_q;
    f14_q <= f13_q;

    x1m_q <= sqp_q * P_COEF_A;
    x2s_q <= $signed(x2p_q) >>> 16;
    p15_q <= p14_q;
    t15_q <= t14_q;
    f15_q <= f14_q;

    res_q.temperature_tenths <= f15_q ? '0 : t15_q;
    res_q.pressure_pascal    <= f15_q ? '0 : p_fin;
    res_q.divide_fault       <= f15_q;
  end

  assign result_valid_o = v16_q;
  assign result_o       = res_q;

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.divide_fault |->
      result_o.temperature_tenths == 0 && result_o.pressure_pascal == 0)
    else $error("fault result carries nonzero data");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, PIPE_LAT))
    else $error("result strobe without matching start");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld |-> $past(v12_q, DIV_STAGES))
    else $error("pressure divider valid out of step");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the barometric temperature and pressure compensation core.
module testbench;
  import bmpc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_t         cmd_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_CAL_A;
  logic [63:0] cfg_data_i = '0;

  barometric_temp_pressure_compensation_core dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the calibration registers
  logic [63:0] cal_a = '0, cal_b = '0;
  logic [31:0] cal_c = '0;
  logic [1:0]  oss_set = '0;

  in_t  pending_q[$];
  out_t compensated_q[$];
  bit   no_gaps = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   phases_run = 0;
  int   idle_cycles = 0;

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_t compensate(in_t c);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, t, p, dv;
    out_t r;
    ac1 = sx16(cal_a[63:48]); ac2 = sx16(cal_a[47:32]);
    ac3 = sx16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = sx16(cal_b[31:16]); b2 = sx16(cal_b[15:0]);
    mc = sx16(cal_c[31:16]); md = sx16(cal_c[15:0]);
    ut = {16'd0, c.raw_temperature};
    up = {8'd0, c.raw_pressure_bytes} >> (8 - oss_set);
    r = '0;
    r.divide_fault = 1'b1;
    x1 = asr((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) return r;
    x2 = sdiv(mc << 11, dv);
    b5 = x1 + x2;
    t = asr(b5 + 32'd8, 4);
    b6 = b5 - B6_OFFSET;
    x1 = asr(b2 * asr(b6 * b6, 12), 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr((((ac1 << 2) + x3) << oss_set) + 32'd2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * asr(b6 * b6, 12), 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + X3_BIAS)) >> 15;
    b7 = (up - b3) * (B7_SCALE >> oss_set);
    if (b4 == 0) return r;
    if (b7 < B7_TOP) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * P_COEF_A, 16);
    x2 = asr(P_COEF_B * p, 16);
    p = p + asr(x1 + x2 + P_OFFSET, 4);
    r.temperature_tenths = t;
    r.pressure_pascal = p;
    r.divide_fault = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    logic nxt;
    nxt = start_i;
    if (start_i && !busy_o) begin
      compensated_q.push_back(compensate(cmd_i));
      nxt = 1'b0;
    end
    if (!nxt && rst_ni) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_q.size() > 0) begin
        cmd_i <= pending_q.pop_front();
        nxt = 1'b1;
        gap <= pick_gap();
      end
    end
    start_i <= nxt;
  end

  // monitor
  always @(posedge clk_i) begin
    out_t e;
    if (result_valid_o) begin
      results_seen++;
      if (compensated_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %h", $time, result_o);
      end else begin
        e = compensated_q.pop_front();
        if (result_o.temperature_tenths !== e.temperature_tenths) begin
          mismatches++;
          $display("%0t: temperature expected %0d actual %0d", $time,
                   e.temperature_tenths, result_o.temperature_tenths);
        end
        if (result_o.pressure_pascal !== e.pressure_pascal) begin
          mismatches++;
          $display("%0t: pressure expected %0d actual %0d", $time,
                   e.pressure_pascal, result_o.pressure_pascal);
        end
        if (result_o.divide_fault !== e.divide_fault) begin
          mismatches++;
          $display("%0t: fault expected %0b actual %0b", $time,
                   e.divide_fault, result_o.divide_fault);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_CAL_A: cal_a = data;
      CFG_CAL_B: cal_b = data;
      CFG_CAL_C: cal_c = data[31:0];
      default:   oss_set = data[1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] o);
    write_reg(CFG_CAL_A, a);
    write_reg(CFG_CAL_B, b);
    write_reg(CFG_CAL_C, c);
    write_reg(CFG_OSS, o);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start_i || compensated_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    phases_run++;
  endtask

  task automatic push_item(logic [15:0] ut, logic [23:0] up);
    in_t c;
    c.raw_temperature = ut;
    c.raw_pressure_bytes = up;
    pending_q.push_back(c);
  endtask

  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0)
        push_item(16'($urandom_range(20000, 36000)),
                  24'($urandom_range(18000, 26000) << 8 | $urandom_range(0, 255)));
      else
        push_item(16'($urandom), 24'($urandom));
    end
  endtask

  // typical factory calibration
  localparam logic [63:0] TYP_A = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
  localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
  localparam logic [63:0] TYP_C = {32'd0, 16'hDDE9, 16'd2868};

  initial begin
    logic [63:0] a, b, c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: temperature divisor is zero
    push_item(16'h0000, 24'h000000);
    push_item(16'hFFFF, 24'hFFFFFF);
    drain();

    load_cal(TYP_A, TYP_B, TYP_C, 64'd0);
    push_item(16'd27898, 24'd23843 << 8);
    push_item(16'h0000, 24'h000000);
    push_item(16'hFFFF, 24'hFFFFFF);
    push_item(16'h0000, 24'hFFFFFF);
    push_item(16'hFFFF, 24'h000000);
    push_item(16'h8000, 24'h800000);
    drain();

    // maximum oversampling, upper bits of the data dropped
    load_cal(TYP_A, TYP_B, {32'hFFFF_FFFF, TYP_C[31:0]}, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(16'd27898, 24'hFFFFFF);
    push_item(16'd27898, 24'h000000);
    push_item(16'h7FFF, 24'h5D2300);
    drain();

    // pressure divisor zero (AC4 zero)
    load_cal({TYP_A[63:16], 16'd0}, TYP_B, TYP_C, 64'd1);
    push_item(16'd27898, 24'd23843 << 8);
    push_item(16'hFFFF, 24'h123456);
    drain();

    // temperature divisor zero with nonzero MC (AC5 and MD zero)
    load_cal(TYP_A, {16'd0, TYP_B[47:0]}, {32'd0, 16'h8000, 16'd0}, 64'd2);
    push_item(16'd1000, 24'hABCDEF);
    drain();

    // all-ones calibration, then a negative divisor: MC<<11 = -32768, divisor -1
    load_cal('1, '1, 64'hFFFF_FFFF, 64'd3);
    push_item(16'h0000, 24'h000000);
    push_item(16'hFFFF, 24'hFFFFFF);
    drain();
    load_cal(TYP_A, {16'd0, TYP_B[47:0]}, {32'd0, 16'hFFF0, 16'hFFFF}, 64'd0);
    push_item(16'd5, 24'h777777);
    drain();

    // random part: mostly typical-like calibration, some fully random
    for (int ph = 0; ph < 16; ph++) begin
      no_gaps = (ph % 5 == 4);
      if (ph % 4 == 3) begin
        a = {$urandom, $urandom}; b = {$urandom, $urandom}; c = {$urandom, $urandom};
      end else begin
        a = TYP_A ^ {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 32'd0} ^
            {48'd0, 16'($urandom_range(0, 1023))};
        b = TYP_B ^ {16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 255)), 16'($urandom_range(0, 7))};
        c = TYP_C ^ {32'($urandom), 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))};
      end
      load_cal(a, b, c, 64'(ph % 4));
      push_random(100);
      drain();
    end

    $display("Ran %0d calibration phases, %0d results checked, all four oversampling settings.",
             phases_run, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
